// ===== rtl/gn2d_pkg.sv =====
// Shared types, constants and helpers for the 2-D gradient noise core.
`default_nettype none
package gn2d_pkg;

    // Load and evaluate codes carried by the input func field.
    typedef enum logic [1:0] {
        FUNC_PERM = 2'd0,
        FUNC_GRAD = 2'd1,
        FUNC_EVAL = 2'd2
    } func_t;

    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned IDX_W   = 8;
    localparam int unsigned PERM_W  = 8;
    localparam int unsigned GRAD_W  = 16;
    localparam int unsigned COORD_W = 32;
    localparam int unsigned NOISE_W = 16;

    // Depth of the permutation and gradient tables, addressed by the 8-bit index.
    localparam int unsigned TABLE_SIZE = 256;

    // Fade arithmetic: Q0.16 fraction, 20-bit intermediates, 17-bit weight.
    localparam int unsigned T_W    = 16;
    localparam int unsigned FADE_W = 20;
    localparam int unsigned WGT_W  = 17;
    localparam logic [FADE_W-1:0] FADE_C15 = 20'd983040;
    localparam logic [FADE_W-1:0] FADE_C10 = 20'd655360;
    localparam logic [FADE_W-1:0] FADE_C6  = 20'd6;

    // Dot products (Q30) and interpolation widths.
    localparam int unsigned OFS_W  = T_W + 2;
    localparam int unsigned PROD_W = GRAD_W + OFS_W;
    localparam int unsigned DOT_W  = PROD_W + 1;
    localparam int unsigned LRP_W  = DOT_W + 1;
    localparam int unsigned RES_W  = LRP_W + 2;

    localparam logic signed [RES_W-1:0] NOISE_BIAS = RES_W'(32768);
    localparam logic signed [RES_W-1:0] NOISE_MAX  = RES_W'(65535);

    // One fade step: (a * t) >> 16 with a below 2^20 and the result below 2^20.
    function automatic logic [FADE_W-1:0] fade_mul(input logic [FADE_W-1:0] a,
                                                   input logic [T_W-1:0] t);
        logic [FADE_W+T_W-1:0] prod;
        prod = (FADE_W+T_W)'(a) * (FADE_W+T_W)'(t);
        return prod[FADE_W+T_W-1:T_W];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/gradient_noise_2d_core.sv =====
// Top level of the pipelined two-dimensional gradient noise core.
//
// The core takes beats on the s_ channel. A beat with s_func equal to a
// permutation load writes s_perm_value at s_index; a gradient load writes the
// pair s_grad_x, s_grad_y at s_index. Loads produce no result. An evaluate beat
// carries a signed fixed-point point in s_coord_x, s_coord_y and produces one
// m_ beat whose m_noise is the noise value in unsigned Q0.16. Code 3 is taken
// and dropped. Tables must be loaded before evaluate beats read them.
//
// The datapath is a ten-stage pipeline followed by the output register: one
// result leaves per cycle and a new beat is taken every cycle while the output
// flows. An evaluate beat passes every stage and the output register on its way
// to m_. Each stage moves when it is empty or when the stage after it
// moves, so bubbles close up during a stall; s_ready follows m_ready through
// that chain of stage enables within the same cycle. The tables are copied
// per pipeline stage that reads them; a load walks down the pipeline and writes
// each copy at the stage where that copy is read, which keeps every evaluate
// ordered against the loads around it.
//
// Synchronous active-low reset empties the pipeline and the output register.
// Table contents survive reset and hold nothing useful until loaded.
`default_nettype none
module gradient_noise_2d_core #(
    parameter int unsigned COORD_FRAC_BITS = 16
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire  [gn2d_pkg::FUNC_W-1:0]          s_func,
    input  wire  [gn2d_pkg::IDX_W-1:0]           s_index,
    input  wire  [gn2d_pkg::PERM_W-1:0]          s_perm_value,
    input  wire  signed [gn2d_pkg::GRAD_W-1:0]   s_grad_x,
    input  wire  signed [gn2d_pkg::GRAD_W-1:0]   s_grad_y,
    input  wire  signed [gn2d_pkg::COORD_W-1:0]  s_coord_x,
    input  wire  signed [gn2d_pkg::COORD_W-1:0]  s_coord_y,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic [gn2d_pkg::NOISE_W-1:0]         m_noise
);

    localparam int unsigned TABLE_SIZE = gn2d_pkg::TABLE_SIZE;
    localparam int unsigned AW = $clog2(TABLE_SIZE);
    localparam int unsigned TW = gn2d_pkg::T_W;
    localparam int unsigned FW = gn2d_pkg::FADE_W;
    localparam int unsigned UW = gn2d_pkg::WGT_W;
    localparam int unsigned GW = gn2d_pkg::GRAD_W;
    localparam int unsigned OW = gn2d_pkg::OFS_W;
    localparam int unsigned PW = gn2d_pkg::PROD_W;
    localparam int unsigned DW = gn2d_pkg::DOT_W;
    localparam int unsigned LW = gn2d_pkg::LRP_W;
    localparam int unsigned RW = gn2d_pkg::RES_W;
    localparam int unsigned NS = 10;

    // Table copies: one for the cell lookup, two for the corner hashes and two
    // for each gradient component.
    logic [gn2d_pkg::PERM_W-1:0] perm_a_mem  [TABLE_SIZE];
    logic [gn2d_pkg::PERM_W-1:0] perm_b0_mem [TABLE_SIZE];
    logic [gn2d_pkg::PERM_W-1:0] perm_b1_mem [TABLE_SIZE];
    logic [GW-1:0]               gx0_mem     [TABLE_SIZE];
    logic [GW-1:0]               gx1_mem     [TABLE_SIZE];
    logic [GW-1:0]               gy0_mem     [TABLE_SIZE];
    logic [GW-1:0]               gy1_mem     [TABLE_SIZE];

    // Stage valid bits and the stage move enables.
    logic [NS:1] v_reg;
    logic [NS:1] en;
    logic        m_valid_reg;
    logic        en_out;

    always_comb begin
        en_out = !m_valid_reg || m_ready;
        en[NS] = !v_reg[NS] || en_out;
        for (int k = NS - 1; k >= 1; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_ready = en[1];
    assign m_valid = m_valid_reg;

    // ---------------- Stage 1: split the point, look up the cell row.
    logic [47:0]            fx_ext, fy_ext;
    logic signed [31:0]     whole_x, whole_y;
    logic [AW-1:0]          cell_x_next, cell_y_next, cell_x1_next, in_idx;
    logic [TW-1:0]          tx_next, ty_next;
    logic [FW-1:0]          px, py;
    logic                   in_take;
    gn2d_pkg::func_t        in_func;

    always_comb begin
        in_func     = gn2d_pkg::func_t'(s_func);
        in_take     = s_valid && en[1];
        in_idx      = AW'({{AW{1'b0}}, s_index});
        whole_x     = s_coord_x >>> COORD_FRAC_BITS;
        whole_y     = s_coord_y >>> COORD_FRAC_BITS;
        cell_x_next = whole_x[AW-1:0];
        cell_y_next = whole_y[AW-1:0];
        cell_x1_next = cell_x_next + AW'(1);
        fx_ext      = {s_coord_x, 16'b0};
        fy_ext      = {s_coord_y, 16'b0};
        tx_next     = fx_ext[COORD_FRAC_BITS +: TW];
        ty_next     = fy_ext[COORD_FRAC_BITS +: TW];
        px = gn2d_pkg::FADE_C15 - FW'(gn2d_pkg::FADE_C6 * FW'(tx_next));
        py = gn2d_pkg::FADE_C15 - FW'(gn2d_pkg::FADE_C6 * FW'(ty_next));
    end

    gn2d_pkg::func_t          op1_reg;
    logic [AW-1:0]            idx1_reg, cy1_reg;
    logic [gn2d_pkg::PERM_W-1:0] pv1_reg, pa1_reg, pb1_reg;
    logic [GW-1:0]            gx1_reg, gy1_reg;
    logic [TW-1:0]            tx1_reg, ty1_reg;
    logic [FW-1:0]            ptx1_reg, pty1_reg;

    always_ff @(posedge aclk) begin
        if (in_take && in_func == gn2d_pkg::FUNC_PERM) begin
            perm_a_mem[in_idx] <= s_perm_value;
        end
        if (en[1]) begin
            op1_reg  <= in_func;
            idx1_reg <= in_idx;
            pv1_reg  <= s_perm_value;
            gx1_reg  <= s_grad_x;
            gy1_reg  <= s_grad_y;
            cy1_reg  <= cell_y_next;
            tx1_reg  <= tx_next;
            ty1_reg  <= ty_next;
            ptx1_reg <= gn2d_pkg::fade_mul(px, tx_next);
            pty1_reg <= gn2d_pkg::fade_mul(py, ty_next);
            pa1_reg  <= perm_a_mem[cell_x_next];
            pb1_reg  <= perm_a_mem[cell_x1_next];
        end
    end

    // ---------------- Stage 2: hash the four corners.
    logic [AW-1:0] pa_m, pb_m, h_aa, h_ba, h_ab, h_bb;

    always_comb begin
        pa_m = AW'({{AW{1'b0}}, pa1_reg});
        pb_m = AW'({{AW{1'b0}}, pb1_reg});
        h_aa = pa_m + cy1_reg;
        h_ba = pb_m + cy1_reg;
        h_ab = h_aa + AW'(1);
        h_bb = h_ba + AW'(1);
    end

    gn2d_pkg::func_t             op2_reg;
    logic [AW-1:0]               idx2_reg;
    logic [GW-1:0]               gx2_reg, gy2_reg;
    logic [TW-1:0]               tx2_reg, ty2_reg;
    logic [FW-1:0]               r1x2_reg, r1y2_reg;
    logic [gn2d_pkg::PERM_W-1:0] g_aa2_reg, g_ba2_reg, g_ab2_reg, g_bb2_reg;

    always_ff @(posedge aclk) begin
        if (en[2] && v_reg[1] && op1_reg == gn2d_pkg::FUNC_PERM) begin
            perm_b0_mem[idx1_reg] <= pv1_reg;
            perm_b1_mem[idx1_reg] <= pv1_reg;
        end
        if (en[2]) begin
            op2_reg   <= op1_reg;
            idx2_reg  <= idx1_reg;
            gx2_reg   <= gx1_reg;
            gy2_reg   <= gy1_reg;
            tx2_reg   <= tx1_reg;
            ty2_reg   <= ty1_reg;
            r1x2_reg  <= gn2d_pkg::fade_mul(gn2d_pkg::FADE_C10 - ptx1_reg, tx1_reg);
            r1y2_reg  <= gn2d_pkg::fade_mul(gn2d_pkg::FADE_C10 - pty1_reg, ty1_reg);
            g_aa2_reg <= perm_b0_mem[h_aa];
            g_ba2_reg <= perm_b0_mem[h_ba];
            g_ab2_reg <= perm_b1_mem[h_ab];
            g_bb2_reg <= perm_b1_mem[h_bb];
        end
    end

    // ---------------- Stage 3: fetch the corner gradients.
    logic [AW-1:0] ga_aa, ga_ba, ga_ab, ga_bb;

    always_comb begin
        ga_aa = AW'({{AW{1'b0}}, g_aa2_reg});
        ga_ba = AW'({{AW{1'b0}}, g_ba2_reg});
        ga_ab = AW'({{AW{1'b0}}, g_ab2_reg});
        ga_bb = AW'({{AW{1'b0}}, g_bb2_reg});
    end

    logic [TW-1:0] tx3_reg, ty3_reg;
    logic [FW-1:0] r2x3_reg, r2y3_reg;
    logic [GW-1:0] gxaa3_reg, gxba3_reg, gxab3_reg, gxbb3_reg;
    logic [GW-1:0] gyaa3_reg, gyba3_reg, gyab3_reg, gybb3_reg;

    always_ff @(posedge aclk) begin
        if (en[3] && v_reg[2] && op2_reg == gn2d_pkg::FUNC_GRAD) begin
            gx0_mem[idx2_reg] <= gx2_reg;
            gx1_mem[idx2_reg] <= gx2_reg;
            gy0_mem[idx2_reg] <= gy2_reg;
            gy1_mem[idx2_reg] <= gy2_reg;
        end
        if (en[3]) begin
            tx3_reg   <= tx2_reg;
            ty3_reg   <= ty2_reg;
            r2x3_reg  <= gn2d_pkg::fade_mul(r1x2_reg, tx2_reg);
            r2y3_reg  <= gn2d_pkg::fade_mul(r1y2_reg, ty2_reg);
            gxaa3_reg <= gx0_mem[ga_aa];
            gxba3_reg <= gx0_mem[ga_ba];
            gxab3_reg <= gx1_mem[ga_ab];
            gxbb3_reg <= gx1_mem[ga_bb];
            gyaa3_reg <= gy0_mem[ga_aa];
            gyba3_reg <= gy0_mem[ga_ba];
            gyab3_reg <= gy1_mem[ga_ab];
            gybb3_reg <= gy1_mem[ga_bb];
        end
    end

    // ---------------- Stage 4: gradient times offset, last fade step.
    // The offset t - 1.0 is t with the two top bits set in 18-bit two's complement.
    logic signed [OW-1:0] dx0, dx1, dy0, dy1;
    logic [FW-1:0]        ux_full, vy_full;

    always_comb begin
        dx0 = $signed({2'b00, tx3_reg});
        dx1 = $signed({2'b11, tx3_reg});
        dy0 = $signed({2'b00, ty3_reg});
        dy1 = $signed({2'b11, ty3_reg});
        ux_full = gn2d_pkg::fade_mul(r2x3_reg, tx3_reg);
        vy_full = gn2d_pkg::fade_mul(r2y3_reg, ty3_reg);
    end

    logic signed [PW-1:0] pxaa4_reg, pxba4_reg, pxab4_reg, pxbb4_reg;
    logic signed [PW-1:0] pyaa4_reg, pyba4_reg, pyab4_reg, pybb4_reg;
    logic [UW-1:0]        u4_reg, v4_reg;

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            pxaa4_reg <= $signed(gxaa3_reg) * dx0;
            pxba4_reg <= $signed(gxba3_reg) * dx1;
            pxab4_reg <= $signed(gxab3_reg) * dx0;
            pxbb4_reg <= $signed(gxbb3_reg) * dx1;
            pyaa4_reg <= $signed(gyaa3_reg) * dy0;
            pyba4_reg <= $signed(gyba3_reg) * dy0;
            pyab4_reg <= $signed(gyab3_reg) * dy1;
            pybb4_reg <= $signed(gybb3_reg) * dy1;
            u4_reg    <= ux_full[UW-1:0];
            v4_reg    <= vy_full[UW-1:0];
        end
    end

    // ---------------- Stage 5: corner dot products in Q30.
    logic signed [DW-1:0] aa5_reg, ba5_reg, ab5_reg, bb5_reg;
    logic [UW-1:0]        u5_reg, v5_reg;

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            aa5_reg <= DW'(pxaa4_reg) + DW'(pyaa4_reg);
            ba5_reg <= DW'(pxba4_reg) + DW'(pyba4_reg);
            ab5_reg <= DW'(pxab4_reg) + DW'(pyab4_reg);
            bb5_reg <= DW'(pxbb4_reg) + DW'(pybb4_reg);
            u5_reg  <= u4_reg;
            v5_reg  <= v4_reg;
        end
    end

    // ---------------- Stage 6: differences along x.
    logic signed [LW-1:0] d1_6_reg, d2_6_reg;
    logic signed [DW-1:0] aa6_reg, ab6_reg;
    logic [UW-1:0]        u6_reg, v6_reg;

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            d1_6_reg <= LW'(ba5_reg) - LW'(aa5_reg);
            d2_6_reg <= LW'(bb5_reg) - LW'(ab5_reg);
            aa6_reg  <= aa5_reg;
            ab6_reg  <= ab5_reg;
            u6_reg   <= u5_reg;
            v6_reg   <= v5_reg;
        end
    end

    // ---------------- Stage 7: scale by the x weight, floor of the /65536.
    logic signed [LW+UW:0] sc1_prod, sc2_prod;

    always_comb begin
        sc1_prod = $signed({1'b0, u6_reg}) * d1_6_reg;
        sc2_prod = $signed({1'b0, u6_reg}) * d2_6_reg;
    end

    logic signed [LW-1:0] m1_7_reg, m2_7_reg;
    logic signed [DW-1:0] aa7_reg, ab7_reg;
    logic [UW-1:0]        v7_reg;

    always_ff @(posedge aclk) begin
        if (en[7]) begin
            m1_7_reg <= sc1_prod[LW+15:16];
            m2_7_reg <= sc2_prod[LW+15:16];
            aa7_reg  <= aa6_reg;
            ab7_reg  <= ab6_reg;
            v7_reg   <= v6_reg;
        end
    end

    // ---------------- Stage 8: finish the two x interpolations.
    logic signed [LW-1:0] l1_8_reg, l2_8_reg;
    logic [UW-1:0]        v8_reg;

    always_ff @(posedge aclk) begin
        if (en[8]) begin
            l1_8_reg <= LW'(aa7_reg) + m1_7_reg;
            l2_8_reg <= LW'(ab7_reg) + m2_7_reg;
            v8_reg   <= v7_reg;
        end
    end

    // ---------------- Stage 9: difference along y.
    logic signed [LW:0]   d3_9_reg;
    logic signed [LW-1:0] l1_9_reg;
    logic [UW-1:0]        v9_reg;

    always_ff @(posedge aclk) begin
        if (en[9]) begin
            d3_9_reg <= (LW+1)'(l2_8_reg) - (LW+1)'(l1_8_reg);
            l1_9_reg <= l1_8_reg;
            v9_reg   <= v8_reg;
        end
    end

    // ---------------- Stage 10: scale by the y weight.
    logic signed [LW+UW+1:0] sc3_prod;

    always_comb begin
        sc3_prod = $signed({1'b0, v9_reg}) * d3_9_reg;
    end

    logic signed [LW:0]   m3_10_reg;
    logic signed [LW-1:0] l1_10_reg;

    always_ff @(posedge aclk) begin
        if (en[10]) begin
            m3_10_reg <= sc3_prod[LW+16:16];
            l1_10_reg <= l1_9_reg;
        end
    end

    // ---------------- Output: final add, halve and bias, saturate.
    logic signed [RW-1:0]          res_sum, res_n;
    logic [gn2d_pkg::NOISE_W-1:0]  m_noise_next;
    logic [gn2d_pkg::NOISE_W-1:0]  m_noise_reg;

    always_comb begin
        res_sum = RW'(l1_10_reg) + RW'(m3_10_reg);
        res_n   = (res_sum >>> 15) + gn2d_pkg::NOISE_BIAS;
        if (res_n < 0) begin
            m_noise_next = '0;
        end else if (res_n > gn2d_pkg::NOISE_MAX) begin
            m_noise_next = '1;
        end else begin
            m_noise_next = res_n[gn2d_pkg::NOISE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            m_noise_reg <= m_noise_next;
        end
    end

    assign m_noise = m_noise_reg;

    // Valid bits: loads live through stage 2, only evaluates go further.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en[1]) begin
                v_reg[1] <= s_valid && (in_func == gn2d_pkg::FUNC_PERM ||
                            in_func == gn2d_pkg::FUNC_GRAD || in_func == gn2d_pkg::FUNC_EVAL);
            end
            if (en[2]) begin
                v_reg[2] <= v_reg[1];
            end
            if (en[3]) begin
                v_reg[3] <= v_reg[2] && op2_reg == gn2d_pkg::FUNC_EVAL;
            end
            for (int k = 4; k <= NS; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
            if (en_out) begin
                m_valid_reg <= v_reg[NS];
            end
        end
    end

`ifndef SYNTHESIS
    // A refused input beat means the first stage is holding an item.
    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> v_reg[1])
        else $error("input stalled with an empty first stage");

    // An item in the last stage is never dropped while the output is stalled.
    a_last_stage_held: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[NS] && !en_out |=> v_reg[NS] && m_valid_reg)
        else $error("last stage item lost during output stall");

    // A result is only produced from an item that sat in the last stage.
    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(v_reg[NS]))
        else $error("result appeared without a pipeline item");
`endif

endmodule
`default_nettype wire
